// ----- sv/bdrdc_pkg.sv -----
// ----------------------------------------------------------------------------
// bdrdc_pkg
// Shared types and constants for the button debouncer with repeat and
// double-click detection.
// ----------------------------------------------------------------------------
package bdrdc_pkg;

    localparam int CNT_W      = 12;
    localparam int WIN_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CNT_W-1:0] HOLD_MAX = {CNT_W{1'b1}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_DELAY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_CLICK_WINDOW = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_LIMIT    = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [CNT_W-1:0] RST_LONG_PRESS_DELAY    = 12'd100;
    localparam logic [CNT_W-1:0] RST_REPEAT_INTERVAL     = 12'd20;
    localparam logic [WIN_W-1:0] RST_DOUBLE_CLICK_WINDOW = 8'd4;
    localparam logic [CNT_W-1:0] RST_LONG_PRESS_LIMIT    = 12'd300;

    typedef struct packed {
        logic [CNT_W-1:0] long_press_delay;
        logic [CNT_W-1:0] repeat_interval;
        logic [WIN_W-1:0] double_click_window;
        logic [CNT_W-1:0] long_press_limit;
    } cfg_t;

    typedef struct packed {
        logic press;
        logic dbl;
        logic level;
    } btn_evt_t;

endpackage

// ----- sv/bdrdc_cfg.sv -----
// ----------------------------------------------------------------------------
// bdrdc_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module bdrdc_cfg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [bdrdc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bdrdc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output bdrdc_pkg::cfg_t                    cfg
);
    import bdrdc_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press_delay    <= RST_LONG_PRESS_DELAY;
            cfg_reg.repeat_interval     <= RST_REPEAT_INTERVAL;
            cfg_reg.double_click_window <= RST_DOUBLE_CLICK_WINDOW;
            cfg_reg.long_press_limit    <= RST_LONG_PRESS_LIMIT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LONG_PRESS_DELAY:    cfg_reg.long_press_delay    <= cfg_data[CNT_W-1:0];
                REG_REPEAT_INTERVAL:     cfg_reg.repeat_interval     <= cfg_data[CNT_W-1:0];
                REG_DOUBLE_CLICK_WINDOW: cfg_reg.double_click_window <= cfg_data[WIN_W-1:0];
                REG_LONG_PRESS_LIMIT:    cfg_reg.long_press_limit    <= cfg_data[CNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- sv/bdrdc_button.sv -----
// ----------------------------------------------------------------------------
// bdrdc_button
// Per-button debounce filter, hold and repeat counters and click window.
// ----------------------------------------------------------------------------
module bdrdc_button
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic                  raw,
    input  bdrdc_pkg::cfg_t       cfg,
    output bdrdc_pkg::btn_evt_t   evt
);
    import bdrdc_pkg::*;

    logic [2:0]       hist_reg,    hist_next;
    logic             stable_reg,  stable_next;
    logic [CNT_W-1:0] hold_reg,    hold_next;
    logic [CNT_W-1:0] rep_reg,     rep_next;
    logic [CNT_W-1:0] used_reg,    used_next;
    logic [WIN_W-1:0] timer_reg,   timer_next;
    logic             pending_reg, pending_next;

    logic [CNT_W-1:0] hold_inc;
    logic [CNT_W-1:0] rep_inc;
    logic [WIN_W-1:0] timer_dec;
    logic             agree;
    logic             now;
    logic             press;
    logic             dbl;

    always_comb
    begin
        hist_next    = {hist_reg[1:0], raw};
        stable_next  = stable_reg;
        hold_next    = hold_reg;
        rep_next     = rep_reg;
        used_next    = used_reg;
        timer_next   = timer_reg;
        pending_next = pending_reg;
        press        = 1'b0;
        dbl          = 1'b0;

        agree     = (hist_next == 3'b000) || (hist_next == 3'b111);
        now       = hist_next[0];
        hold_inc  = (hold_reg == HOLD_MAX) ? hold_reg : hold_reg + 1'b1;
        rep_inc   = rep_reg;
        timer_dec = timer_reg - 1'b1;

        if (agree)
        begin
            if (now != stable_reg)
            begin
                stable_next = now;
                hold_next   = '0;
                rep_next    = '0;
                if (!now)
                begin
                    if (pending_reg && (timer_reg != '0))
                    begin
                        dbl          = 1'b1;
                        pending_next = 1'b0;
                        timer_next   = '0;
                    end
                    else
                    begin
                        press        = 1'b1;
                        pending_next = 1'b1;
                        timer_next   = cfg.double_click_window;
                    end
                end
            end
            else if (!now)
            begin
                hold_next = hold_inc;
                if (hold_inc >= cfg.long_press_delay)
                begin
                    // The repeat budget only counts while it lasts; the interval
                    // compare still runs once the budget is spent.
                    if (used_reg < cfg.long_press_limit)
                    begin
                        used_next = used_reg + 1'b1;
                        rep_inc   = rep_reg + 1'b1;
                    end
                    if (rep_inc >= cfg.repeat_interval)
                    begin
                        press    = 1'b1;
                        rep_next = '0;
                    end
                    else
                    begin
                        rep_next = rep_inc;
                    end
                end
            end
            else
            begin
                hold_next = '0;
                rep_next  = '0;
                used_next = '0;
                if (pending_reg && (timer_reg != '0))
                begin
                    timer_next = timer_dec;
                    if (timer_dec == '0)
                    begin
                        pending_next = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg    <= 3'b111;
            stable_reg  <= 1'b1;
            hold_reg    <= '0;
            rep_reg     <= '0;
            used_reg    <= '0;
            timer_reg   <= '0;
            pending_reg <= 1'b0;
        end
        else if (advance)
        begin
            hist_reg    <= hist_next;
            stable_reg  <= stable_next;
            hold_reg    <= hold_next;
            rep_reg     <= rep_next;
            used_reg    <= used_next;
            timer_reg   <= timer_next;
            pending_reg <= pending_next;
        end
    end

    assign evt.press = press;
    assign evt.dbl   = dbl;
    assign evt.level = stable_next;

endmodule

// ----- sv/button_debounce_repeat_double_click.sv -----
// ----------------------------------------------------------------------------
// button_debounce_repeat_double_click
// Debouncer for a row of active-low buttons with press, auto-repeat and
// double-click events, one sample tick per request.
// ----------------------------------------------------------------------------
//  Channel   Direction  Content
//  s_*       in         tdata: raw_levels (BUTTONS bits, 1 released)
//  m_*       out        tdata: press_events, double_click_events, stable_levels
//  cfg_*     in         write enable, register index, 12-bit write data
//
//  One request per cycle while the output is not stalled; each tick passes an input
//  register, the per-button next-state logic, and the result register.
//  Button state advances only when a tick moves into the result register.
//  A stalled result holds while one more request waits in the input register.
//  Reset returns every button to released with all counters cleared.
// ----------------------------------------------------------------------------
module button_debounce_repeat_double_click
#(
    parameter int BUTTONS = 4
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // raw_levels from bit 0
    input  logic [((BUTTONS+7)/8)*8-1:0]          s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // press_events, then double_click_events, then stable_levels, from bit 0
    output logic [((3*BUTTONS+7)/8)*8-1:0]        m_tdata,
    input  logic                                  cfg_we,
    input  logic [bdrdc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bdrdc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import bdrdc_pkg::*;

    localparam int OUT_W = ((3*BUTTONS+7)/8)*8;

    cfg_t                   cfg;
    btn_evt_t               evt [BUTTONS];
    logic                   in_valid_reg;
    logic [BUTTONS-1:0]     in_raw_reg;
    logic                   m_tvalid_reg;
    logic [OUT_W-1:0]       m_tdata_reg;
    logic [OUT_W-1:0]       m_tdata_next;
    logic                   advance;

    bdrdc_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign advance  = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    for (genvar b = 0; b < BUTTONS; b++)
    begin : g_btn
        bdrdc_button u_btn
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .raw     (in_raw_reg[b]),
            .cfg     (cfg),
            .evt     (evt[b])
        );
    end

    always_comb
    begin
        m_tdata_next = '0;
        for (int b = 0; b < BUTTONS; b++)
        begin
            m_tdata_next[b]             = evt[b].press;
            m_tdata_next[BUTTONS + b]   = evt[b].dbl;
            m_tdata_next[2*BUTTONS + b] = evt[b].level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_raw_reg <= s_tdata[BUTTONS-1:0];
        end
        if (advance)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A button never reports a press and a double click in the same tick.
    a_press_dbl_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[BUTTONS-1:0] & m_tdata[2*BUTTONS-1:BUTTONS]) == '0))
        else $error("press and double click on the same button");

    // A double click always comes with the button debounced as pressed.
    a_dbl_when_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[2*BUTTONS-1:BUTTONS] & m_tdata[3*BUTTONS-1:2*BUTTONS]) == '0))
        else $error("double click while button released");

    // An empty result register never blocks the input side.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid_reg |-> s_tready)
        else $error("input stalled with empty result register");

    // An advancing tick is valid in the result register in the next cycle.
    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid_reg)
        else $error("advanced tick did not appear at the output");

endmodule
